### hw/rtl/ctb_pkg.sv
package ctb_pkg;

  // Field widths
  localparam int XW     = 16;          // offsets, signed Q1.15
  localparam int FRAC   = XW - 1;      // fraction bits of an offset
  localparam int RHO_W  = 17;          // correlation, signed Q2.15
  localparam int MAG_W  = RHO_W;       // |rho| needs the full width for -2.0
  localparam int Q16_W  = 17;          // probabilities, unsigned Q1.16

  // Internal widths
  localparam int SQ_W   = 2 * FRAC + 1;    // x^2, at most 2^30
  localparam int KW     = SQ_W + 2;        // x^2 +/- x*2^15
  localparam int MARG_W = 32;              // marginals in Q30, signed
  localparam int PROD_W = 62;              // joint products in Q60
  localparam int EPS_W  = 58;              // clamped correction
  localparam int RES_W  = PROD_W + 1;      // product plus weighted correction
  localparam int RND_SH = 44;              // Q60 to Q16
  localparam int T_W    = RES_W - RND_SH;  // rounded value before saturation

  // Marginals: up = UP_C + floor(k/2), mid = MID_C - x^2 (units of 2^-30)
  localparam logic signed [MARG_W-1:0] UP_C  = MARG_W'(((64'd1 << 30) + 64'd2) / 64'd6);
  localparam logic signed [MARG_W-1:0] MID_C = MARG_W'(((64'd1 << 32) + 64'd3) / 64'd6);

  // eps0 = floor(|rho| * 2^45 / 36) = floor(|rho| * 2^43 / 9)
  localparam int EPS_SH    = 43;
  localparam int EPS_Q_W   = 40;
  localparam int EPS_SPLIT = 20;
  localparam int EPS0_W    = MAG_W + EPS_SH - 3;
  localparam logic [EPS_Q_W-1:0] EPS_Q = EPS_Q_W'((64'd1 << EPS_SH) / 64'd9);
  localparam logic [EPS_Q_W-EPS_SPLIT-1:0] EPS_Q_HI = EPS_Q[EPS_Q_W-1:EPS_SPLIT];
  localparam logic [EPS_SPLIT-1:0] EPS_Q_LO = EPS_Q[EPS_SPLIT-1:0];
  localparam logic [1:0] EPS_REM = 2'((64'd1 << EPS_SH) % 64'd9);
  localparam int N_W       = MAG_W + 2;    // |rho| * remainder
  localparam int DIV9_SH   = 21;
  localparam int DIV9_W    = 18;
  localparam logic [DIV9_W-1:0] DIV9_RECIP = DIV9_W'((64'd1 << DIV9_SH) / 64'd9 + 64'd1);

  localparam logic [RES_W-1:0] RND_HALF = RES_W'(64'd1 << (RND_SH - 1));
  localparam logic [Q16_W-1:0] Q16_ONE  = Q16_W'(64'd1 << 16);

  // Pipeline stages
  localparam int STG_SQ   = 0;
  localparam int STG_MARG = 1;
  localparam int STG_PROD = 2;
  localparam int STG_LIM  = 3;
  localparam int STG_EPS  = 4;
  localparam int STG_RES  = 5;
  localparam int STG_OUT  = 6;
  localparam int NSTG     = 7;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [EPS0_W-1:0] eps0;
    logic              pos;
  } corr_t;

  typedef struct packed {
    logic signed [MARG_W-1:0] up;
    logic signed [MARG_W-1:0] mid;
    logic signed [MARG_W-1:0] dn;
  } marg_t;

  // First letter y branch, second letter u branch
  typedef struct packed {
    logic signed [PROD_W-1:0] dd;
    logic signed [PROD_W-1:0] md;
    logic signed [PROD_W-1:0] ud;
    logic signed [PROD_W-1:0] dm;
    logic signed [PROD_W-1:0] mm;
    logic signed [PROD_W-1:0] um;
    logic signed [PROD_W-1:0] du;
    logic signed [PROD_W-1:0] mu;
    logic signed [PROD_W-1:0] uu;
  } prod9_t;

  typedef struct packed {
    logic signed [RES_W-1:0] dd;
    logic signed [RES_W-1:0] md;
    logic signed [RES_W-1:0] ud;
    logic signed [RES_W-1:0] dm;
    logic signed [RES_W-1:0] mm;
    logic signed [RES_W-1:0] um;
    logic signed [RES_W-1:0] du;
    logic signed [RES_W-1:0] mu;
    logic signed [RES_W-1:0] uu;
  } res9_t;

endpackage

### hw/rtl/ctb_in_if.sv
interface ctb_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ctb_pkg::XW-1:0]   offset_y;
  logic signed [ctb_pkg::XW-1:0]   offset_u;

  modport source (output valid, output offset_y, output offset_u, input ready);
  modport sink   (input valid, input offset_y, input offset_u, output ready);
endinterface

### hw/rtl/ctb_out_if.sv
interface ctb_out_if;
  logic                        valid;
  logic                        ready;
  logic [ctb_pkg::Q16_W-1:0]   p_ydn_udn;
  logic [ctb_pkg::Q16_W-1:0]   p_ymid_udn;
  logic [ctb_pkg::Q16_W-1:0]   p_yup_udn;
  logic [ctb_pkg::Q16_W-1:0]   p_ydn_umid;
  logic [ctb_pkg::Q16_W-1:0]   p_ymid_umid;
  logic [ctb_pkg::Q16_W-1:0]   p_yup_umid;
  logic [ctb_pkg::Q16_W-1:0]   p_ydn_uup;
  logic [ctb_pkg::Q16_W-1:0]   p_ymid_uup;
  logic [ctb_pkg::Q16_W-1:0]   p_yup_uup;

  modport source (
    output valid, input ready,
    output p_ydn_udn, output p_ymid_udn, output p_yup_udn,
    output p_ydn_umid, output p_ymid_umid, output p_yup_umid,
    output p_ydn_uup, output p_ymid_uup, output p_yup_uup
  );
  modport sink (
    input valid, output ready,
    input p_ydn_udn, input p_ymid_udn, input p_yup_udn,
    input p_ydn_umid, input p_ymid_umid, input p_yup_umid,
    input p_ydn_uup, input p_ymid_uup, input p_yup_uup
  );
endinterface

### hw/rtl/ctb_pipe_ctrl.sv
module ctb_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output ctb_pkg::pipe_ctrl_t ctrl_o
);

  logic [ctb_pkg::NSTG-1:0] v_d, v_q;
  logic [ctb_pkg::NSTG-1:0] en;

  // A stage loads when it is empty or its word moves on
  always_comb begin
    en[ctb_pkg::NSTG-1] = !v_q[ctb_pkg::NSTG-1] || out_ready_i;
    for (int i = ctb_pkg::NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < ctb_pkg::NSTG; i++) begin
      v_d[i] = en[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctrl_o.en  = en;
  assign ctrl_o.vld = v_q;

endmodule

### hw/rtl/ctb_eps_gen.sv
module ctb_eps_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ctb_pkg::RHO_W-1:0]  cfg_wdata_i,
  output ctb_pkg::corr_t             corr_o
);

  localparam int PW = ctb_pkg::MAG_W + ctb_pkg::EPS_SPLIT;

  logic signed [ctb_pkg::RHO_W-1:0]                 rho_q;
  logic [ctb_pkg::MAG_W-1:0]                        mag;
  logic [ctb_pkg::N_W-1:0]                          rem_n;
  logic [ctb_pkg::N_W+ctb_pkg::DIV9_W-1:0]          rem_p;
  logic [PW-1:0]                                    ph_d, ph_q, pl_d, pl_q;
  logic [ctb_pkg::N_W-1:0]                          t9_d, t9_q;
  logic                                             pos_d, pos_a_q;
  logic [ctb_pkg::EPS0_W-1:0]                       eps0_d;
  ctb_pkg::corr_t                                   corr_q;

  // Split |rho| * floor(2^43/9) into two narrow partial products
  always_comb begin
    mag   = rho_q[ctb_pkg::RHO_W-1] ? ctb_pkg::MAG_W'(-rho_q) : ctb_pkg::MAG_W'(rho_q);
    ph_d  = mag * ctb_pkg::EPS_Q_HI;
    pl_d  = mag * ctb_pkg::EPS_Q_LO;
    rem_n = mag * ctb_pkg::EPS_REM;
    rem_p = rem_n * ctb_pkg::DIV9_RECIP;
    t9_d  = ctb_pkg::N_W'(rem_p >> ctb_pkg::DIV9_SH);
    pos_d = !rho_q[ctb_pkg::RHO_W-1] && (rho_q != '0);
    eps0_d = ctb_pkg::EPS0_W'({ph_q, {ctb_pkg::EPS_SPLIT{1'b0}}})
           + ctb_pkg::EPS0_W'(pl_q) + ctb_pkg::EPS0_W'(t9_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q   <= '0;
      ph_q    <= '0;
      pl_q    <= '0;
      t9_q    <= '0;
      pos_a_q <= 1'b0;
      corr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        rho_q <= cfg_wdata_i;
      end
      ph_q        <= ph_d;
      pl_q        <= pl_d;
      t9_q        <= t9_d;
      pos_a_q     <= pos_d;
      corr_q.eps0 <= eps0_d;
      corr_q.pos  <= pos_a_q;
    end
  end

  assign corr_o = corr_q;

endmodule

### hw/rtl/ctb_marg.sv
module ctb_marg (
  input  logic                          clk_i,
  input  ctb_pkg::pipe_ctrl_t           ctrl_i,
  input  logic signed [ctb_pkg::XW-1:0] x_y_i,
  input  logic signed [ctb_pkg::XW-1:0] x_u_i,
  output ctb_pkg::marg_t                marg_y_o,
  output ctb_pkg::marg_t                marg_u_o
);

  logic signed [ctb_pkg::XW-1:0]   x_y_q, x_u_q;
  logic signed [2*ctb_pkg::XW-1:0] sqf_y, sqf_u;
  logic [ctb_pkg::SQ_W-1:0]        sq_y_q, sq_u_q;
  ctb_pkg::marg_t                  marg_y_d, marg_u_d, marg_y_q, marg_u_q;

  // up = C + (x^2 + x*2^15)/2, down = C + (x^2 - x*2^15)/2, mid = M - x^2
  function automatic ctb_pkg::marg_t margins(input logic signed [ctb_pkg::XW-1:0] x,
                                             input logic [ctb_pkg::SQ_W-1:0] sq);
    logic signed [ctb_pkg::KW-1:0] xs, sqs, kp, kn;
    ctb_pkg::marg_t m;
    xs    = ctb_pkg::KW'(x) <<< ctb_pkg::FRAC;
    sqs   = $signed(ctb_pkg::KW'(sq));
    kp    = sqs + xs;
    kn    = sqs - xs;
    m.up  = ctb_pkg::UP_C + ctb_pkg::MARG_W'(kp >>> 1);
    m.dn  = ctb_pkg::UP_C + ctb_pkg::MARG_W'(kn >>> 1);
    m.mid = ctb_pkg::MID_C - $signed(ctb_pkg::MARG_W'(sq));
    return m;
  endfunction

  assign sqf_y    = x_y_i * x_y_i;
  assign sqf_u    = x_u_i * x_u_i;
  assign marg_y_d = margins(x_y_q, sq_y_q);
  assign marg_u_d = margins(x_u_q, sq_u_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ctb_pkg::STG_SQ]) begin
      x_y_q  <= x_y_i;
      x_u_q  <= x_u_i;
      sq_y_q <= sqf_y[ctb_pkg::SQ_W-1:0];
      sq_u_q <= sqf_u[ctb_pkg::SQ_W-1:0];
    end
    if (ctrl_i.en[ctb_pkg::STG_MARG]) begin
      marg_y_q <= marg_y_d;
      marg_u_q <= marg_u_d;
    end
  end

  assign marg_y_o = marg_y_q;
  assign marg_u_o = marg_u_q;

endmodule

### hw/rtl/ctb_joint.sv
module ctb_joint (
  input  logic                             clk_i,
  input  ctb_pkg::pipe_ctrl_t              ctrl_i,
  input  ctb_pkg::corr_t                   corr_i,
  input  ctb_pkg::marg_t                   marg_y_i,
  input  ctb_pkg::marg_t                   marg_u_i,
  output ctb_pkg::prod9_t                  prod_o,
  output logic signed [ctb_pkg::EPS_W-1:0] eps_o
);

  ctb_pkg::prod9_t                    prod_d, prod2_q, prod3_q, prod4_q;
  logic signed [ctb_pkg::PROD_W-1:0]  lim_a_d, lim_b_d, lim_c_d;
  logic signed [ctb_pkg::PROD_W-1:0]  lim_a_q, lim_b_q, lim_c_q;
  logic signed [ctb_pkg::PROD_W-1:0]  eps0_s, eps_full;
  logic signed [ctb_pkg::EPS_W-1:0]   eps_q;

  function automatic logic signed [ctb_pkg::PROD_W-1:0] mul(
      input logic signed [ctb_pkg::MARG_W-1:0] a,
      input logic signed [ctb_pkg::MARG_W-1:0] b);
    logic signed [2*ctb_pkg::MARG_W-1:0] f;
    f = a * b;
    return f[ctb_pkg::PROD_W-1:0];
  endfunction

  function automatic logic signed [ctb_pkg::PROD_W-1:0] smin(
      input logic signed [ctb_pkg::PROD_W-1:0] a,
      input logic signed [ctb_pkg::PROD_W-1:0] b);
    return (a > b) ? b : a;
  endfunction

  always_comb begin
    prod_d.dd = mul(marg_y_i.dn,  marg_u_i.dn);
    prod_d.md = mul(marg_y_i.mid, marg_u_i.dn);
    prod_d.ud = mul(marg_y_i.up,  marg_u_i.dn);
    prod_d.dm = mul(marg_y_i.dn,  marg_u_i.mid);
    prod_d.mm = mul(marg_y_i.mid, marg_u_i.mid);
    prod_d.um = mul(marg_y_i.up,  marg_u_i.mid);
    prod_d.du = mul(marg_y_i.dn,  marg_u_i.up);
    prod_d.mu = mul(marg_y_i.mid, marg_u_i.up);
    prod_d.uu = mul(marg_y_i.up,  marg_u_i.up);
  end

  // Quarter limits on the edge branches, corner limits by sign of rho
  always_comb begin
    lim_a_d = smin(prod2_q.dm >>> 2, prod2_q.md >>> 2);
    lim_b_d = smin(prod2_q.mu >>> 2, prod2_q.um >>> 2);
    lim_c_d = corr_i.pos ? smin(prod2_q.du, prod2_q.ud) : smin(prod2_q.uu, prod2_q.dd);
  end

  assign eps0_s   = $signed(ctb_pkg::PROD_W'(corr_i.eps0));
  assign eps_full = smin(smin(lim_a_q, lim_b_q), smin(lim_c_q, eps0_s));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ctb_pkg::STG_PROD]) begin
      prod2_q <= prod_d;
    end
    if (ctrl_i.en[ctb_pkg::STG_LIM]) begin
      prod3_q <= prod2_q;
      lim_a_q <= lim_a_d;
      lim_b_q <= lim_b_d;
      lim_c_q <= lim_c_d;
    end
    if (ctrl_i.en[ctb_pkg::STG_EPS]) begin
      prod4_q <= prod3_q;
      eps_q   <= eps_full[ctb_pkg::EPS_W-1:0];
    end
  end

  assign prod_o = prod4_q;
  assign eps_o  = eps_q;

endmodule

### hw/rtl/ctb_quant.sv
module ctb_quant (
  input  logic                             clk_i,
  input  ctb_pkg::pipe_ctrl_t              ctrl_i,
  input  ctb_pkg::corr_t                   corr_i,
  input  ctb_pkg::prod9_t                  prod_i,
  input  logic signed [ctb_pkg::EPS_W-1:0] eps_i,
  ctb_out_if.source                        out_o
);

  typedef struct packed {
    logic [ctb_pkg::Q16_W-1:0] dd;
    logic [ctb_pkg::Q16_W-1:0] md;
    logic [ctb_pkg::Q16_W-1:0] ud;
    logic [ctb_pkg::Q16_W-1:0] dm;
    logic [ctb_pkg::Q16_W-1:0] mm;
    logic [ctb_pkg::Q16_W-1:0] um;
    logic [ctb_pkg::Q16_W-1:0] du;
    logic [ctb_pkg::Q16_W-1:0] mu;
    logic [ctb_pkg::Q16_W-1:0] uu;
  } q9_t;

  ctb_pkg::res9_t                   res_d, res_q;
  q9_t                              q_d, q_q;
  logic signed [ctb_pkg::RES_W-1:0] e, e4, e5, e8, e_corner, e_anti;

  // Round half up from Q60, clip to [0,1]
  function automatic logic [ctb_pkg::Q16_W-1:0] to_q16(
      input logic signed [ctb_pkg::RES_W-1:0] v);
    logic [ctb_pkg::RES_W-1:0] s;
    logic [ctb_pkg::T_W-1:0]   t;
    logic [ctb_pkg::Q16_W-1:0] q;
    s = $unsigned(v) + ctb_pkg::RND_HALF;
    t = s[ctb_pkg::RES_W-1:ctb_pkg::RND_SH];
    if (v <= 0) begin
      q = '0;
    end else if (t > ctb_pkg::T_W'(ctb_pkg::Q16_ONE)) begin
      q = ctb_pkg::Q16_ONE;
    end else begin
      q = t[ctb_pkg::Q16_W-1:0];
    end
    return q;
  endfunction

  always_comb begin
    e  = ctb_pkg::RES_W'(eps_i);
    e4 = e <<< 2;
    e8 = e <<< 3;
    e5 = e4 + e;
    // Positive rho favours the diagonal corners, otherwise the anti-diagonal
    e_corner = corr_i.pos ? e5 : -e;
    e_anti   = corr_i.pos ? -e : e5;
    res_d.dd = ctb_pkg::RES_W'(prod_i.dd) + e_corner;
    res_d.uu = ctb_pkg::RES_W'(prod_i.uu) + e_corner;
    res_d.ud = ctb_pkg::RES_W'(prod_i.ud) + e_anti;
    res_d.du = ctb_pkg::RES_W'(prod_i.du) + e_anti;
    res_d.md = ctb_pkg::RES_W'(prod_i.md) - e4;
    res_d.dm = ctb_pkg::RES_W'(prod_i.dm) - e4;
    res_d.um = ctb_pkg::RES_W'(prod_i.um) - e4;
    res_d.mu = ctb_pkg::RES_W'(prod_i.mu) - e4;
    res_d.mm = ctb_pkg::RES_W'(prod_i.mm) + e8;
  end

  always_comb begin
    q_d.dd = to_q16(res_q.dd);
    q_d.md = to_q16(res_q.md);
    q_d.ud = to_q16(res_q.ud);
    q_d.dm = to_q16(res_q.dm);
    q_d.mm = to_q16(res_q.mm);
    q_d.um = to_q16(res_q.um);
    q_d.du = to_q16(res_q.du);
    q_d.mu = to_q16(res_q.mu);
    q_d.uu = to_q16(res_q.uu);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ctb_pkg::STG_RES]) begin
      res_q <= res_d;
    end
    if (ctrl_i.en[ctb_pkg::STG_OUT]) begin
      q_q <= q_d;
    end
  end

  assign out_o.valid       = ctrl_i.vld[ctb_pkg::STG_OUT];
  assign out_o.p_ydn_udn   = q_q.dd;
  assign out_o.p_ymid_udn  = q_q.md;
  assign out_o.p_yup_udn   = q_q.ud;
  assign out_o.p_ydn_umid  = q_q.dm;
  assign out_o.p_ymid_umid = q_q.mm;
  assign out_o.p_yup_umid  = q_q.um;
  assign out_o.p_ydn_uup   = q_q.du;
  assign out_o.p_ymid_uup  = q_q.mu;
  assign out_o.p_yup_uup   = q_q.uu;

endmodule

### hw/rtl/correlated_trinomial_branch_probs.sv
// Branch probabilities of one node of a correlated two-factor trinomial tree.
// Each input word carries the y and u drift offsets (signed Q1.15); each result
// word carries the nine joint probabilities (unsigned Q1.16, clipped to [0,1]).
// The block is a seven-stage pipeline: square, marginals, nine 32x32 products,
// limit compares, correction select, weighted sums, rounding. It takes one word
// per clock while the output is not stalled, and so sustains one node per cycle;
// the product stage's nine multipliers each take a new word every such cycle.
// A stall on the output holds the words queued behind it and loses nothing,
// while empty stages still fill from the input. The user must write the
// correlation register through cfg_we_i/cfg_wdata_i only while no word is in
// flight; the block itself does not enforce this. Its derived correction passes
// the partial product and output registers before a new word reaches the stages that use it.
module correlated_trinomial_branch_probs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ctb_pkg::RHO_W-1:0]  cfg_wdata_i,
  ctb_in_if.sink                     in_i,
  ctb_out_if.source                  out_o
);

  ctb_pkg::pipe_ctrl_t              ctrl;
  ctb_pkg::corr_t                   corr;
  ctb_pkg::marg_t                   marg_y, marg_u;
  ctb_pkg::prod9_t                  prod;
  logic signed [ctb_pkg::EPS_W-1:0] eps;

  // Take a word whenever the first stage can load
  assign in_i.ready = ctrl.en[ctb_pkg::STG_SQ];

  // Valid bits and stage enables: advance where the next stage has room
  ctb_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  // Correlation register and its unclamped correction |rho|/36
  ctb_eps_gen u_eps_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .corr_o      (corr)
  );

  // Stages one and two: per-factor up, middle and down marginals in Q30
  ctb_marg u_marg (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .x_y_i    (in_i.offset_y),
    .x_u_i    (in_i.offset_u),
    .marg_y_o (marg_y),
    .marg_u_o (marg_u)
  );

  // Stages three to five: joint products, the six limits, clamped correction
  ctb_joint u_joint (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .corr_i   (corr),
    .marg_y_i (marg_y),
    .marg_u_i (marg_u),
    .prod_o   (prod),
    .eps_o    (eps)
  );

  // Stages six and seven: apply weighted correction, round, drive the result word
  ctb_quant u_quant (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .corr_i (corr),
    .prod_i (prod),
    .eps_i  (eps),
    .out_o  (out_o)
  );

endmodule
